@@ rtl/udpchk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package udpchk_pkg;

	// framing and field widths
	localparam int HEADER_BYTES = 16;
	localparam int SEQ_W        = 32;
	localparam int LEN_W        = 11;
	localparam int WORD_W       = 64;
	localparam int CNT_W        = 32;
	localparam int BYTE_LANES   = 8;
	localparam int SKEW_W       = 41;
	localparam int LIMIT_W      = 20;
	localparam int FOLD_W       = 14;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 41;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

	// payload fill byte is 'A' plus sequence modulo 26
	localparam logic [7:0] PATTERN_BASE = 8'd65;

	localparam logic [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CLOCK_SKEW   = 2'd0,
		REG_SAMPLE_LIMIT = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		VERDICT_FIRST = 3'd0,
		VERDICT_IN_ORDER = 3'd1,
		VERDICT_GAP = 3'd2,
		VERDICT_OUT_OF_ORDER = 3'd3,
		VERDICT_TOO_SHORT = 3'd4,
		VERDICT_MISMATCH = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq_number;
		logic [LEN_W-1:0]  datagram_bytes;
		logic [WORD_W-1:0] head_word;
		logic [WORD_W-1:0] tail_word;
		logic [WORD_W-1:0] arrival_ns;
		logic [WORD_W-1:0] sent_ns;
	} in_t;

	typedef struct packed {
		verdict_t                 verdict;
		logic [CNT_W-1:0]         valid_count;
		logic [CNT_W-1:0]         corrupt_count;
		logic [CNT_W-1:0]         lost_count;
		logic [CNT_W-1:0]         reorder_count;
		logic [WORD_W-1:0]        byte_total;
		logic [WORD_W-1:0]        payload_total;
		logic signed [WORD_W-1:0] delay_sum;
		logic signed [WORD_W-1:0] delay_min;
		logic signed [WORD_W-1:0] delay_max;
		logic [WORD_W-1:0]        gap_sum;
		logic [WORD_W-1:0]        gap_square_sum;
	} out_t;

	// checked datagram as seen by the statistics stage
	typedef struct packed {
		logic                     short_pkt;
		logic                     bad;
		logic [SEQ_W-1:0]         seq;
		logic [LEN_W-1:0]         len;
		logic [LEN_W-1:0]         pay;
		logic signed [WORD_W-1:0] owd;
		logic [WORD_W-1:0]        arrival;
	} stats_item_t;

	// statistics after one datagram, plus the jitter sample it yields
	typedef struct packed {
		verdict_t                 verdict;
		logic [CNT_W-1:0]         valid_count;
		logic [CNT_W-1:0]         corrupt_count;
		logic [CNT_W-1:0]         lost_count;
		logic [CNT_W-1:0]         reorder_count;
		logic [WORD_W-1:0]        byte_total;
		logic [WORD_W-1:0]        payload_total;
		logic signed [WORD_W-1:0] delay_sum;
		logic signed [WORD_W-1:0] delay_min;
		logic signed [WORD_W-1:0] delay_max;
		logic [WORD_W-1:0]        gap;
		logic                     sample;
	} stats_snap_t;

	// first fold of the sequence number, congruent modulo 26
	function automatic logic [FOLD_W-1:0] seq_fold(input logic [SEQ_W-1:0] s);
		logic [FOLD_W-1:0] t3, t2, t1;
		t3 = FOLD_W'(s[31:24]) * FOLD_W'(14);
		t2 = FOLD_W'(s[23:16]) * FOLD_W'(16);
		t1 = FOLD_W'(s[15:8]) * FOLD_W'(22);
		return t3 + t2 + t1 + FOLD_W'(s[7:0]);
	endfunction

	// finish the modulo 26 on the folded value and form the fill byte
	function automatic logic [7:0] pattern_char(input logic [FOLD_W-1:0] f);
		logic [10:0] a;
		logic [8:0]  b;
		logic [6:0]  c;
		logic [13:0] prod;
		logic [2:0]  q;
		logic [6:0]  r;
		a = 11'(f[13:8]) * 11'd22 + 11'(f[7:0]);
		b = 9'(a[10:8]) * 9'd22 + 9'(a[7:0]);
		c = 7'(b[8:6]) * 7'd12 + 7'(b[5:0]);
		// reciprocal of 26 is exact for values below 128
		prod = 14'(c) * 14'd79;
		q = prod[13:11];
		r = c - 7'(q) * 7'd26;
		return PATTERN_BASE + 8'(r);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] a);
		return (a == '1) ? a : a + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add_u32(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] sat_add_u64(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W] ? '1 : s[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] sat_add_s64(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? S64_MIN : S64_MAX;
		return s[WORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/udpchk_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module udpchk_lane (
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] pattern_byte,
	input  wire logic       enable,
	output logic            mismatch
);

	// one payload byte against the expected fill byte
	assign mismatch = enable && (data_byte != pattern_byte);

endmodule
`default_nettype wire

@@ rtl/udpchk_stats.sv @@
`timescale 1ns / 1ps
`default_nettype none
module udpchk_stats (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          commit,
	input  wire udpchk_pkg::stats_item_t       item,
	input  wire logic [udpchk_pkg::LIMIT_W-1:0] sample_limit,
	output udpchk_pkg::stats_snap_t            snap
);
	import udpchk_pkg::*;

	logic                     started_q;
	logic [SEQ_W-1:0]         next_expected_q;
	logic [WORD_W-1:0]        prev_arrival_q;
	logic [CNT_W-1:0]         valid_q, corrupt_q, lost_q, reorder_q;
	logic [WORD_W-1:0]        bytes_q, payload_q;
	logic signed [WORD_W-1:0] delay_sum_q, delay_low_q, delay_high_q;
	logic [LIMIT_W-1:0]       sample_q;

	logic                     started_n;
	logic [SEQ_W-1:0]         next_expected_n;
	logic [WORD_W-1:0]        prev_arrival_n;
	logic [LIMIT_W-1:0]       sample_n;

	// classify the word and work out the next statistics
	always_comb begin
		snap.verdict       = VERDICT_FIRST;
		snap.valid_count   = valid_q;
		snap.corrupt_count = corrupt_q;
		snap.lost_count    = lost_q;
		snap.reorder_count = reorder_q;
		snap.byte_total    = bytes_q;
		snap.payload_total = payload_q;
		snap.delay_sum     = delay_sum_q;
		snap.delay_min     = delay_low_q;
		snap.delay_max     = delay_high_q;
		snap.gap           = item.arrival - prev_arrival_q;
		snap.sample        = 1'b0;
		started_n          = started_q;
		next_expected_n    = next_expected_q;
		prev_arrival_n     = prev_arrival_q;
		sample_n           = sample_q;
		if (item.short_pkt) begin
			snap.verdict       = VERDICT_TOO_SHORT;
			snap.corrupt_count = sat_inc32(corrupt_q);
		end else if (item.bad) begin
			snap.verdict       = VERDICT_MISMATCH;
			snap.corrupt_count = sat_inc32(corrupt_q);
		end else begin
			if (!started_q) begin
				snap.verdict    = VERDICT_FIRST;
				next_expected_n = item.seq + SEQ_W'(1);
			end else begin
				// jitter sample while under the limit
				if (sample_q < sample_limit) begin
					snap.sample = 1'b1;
					sample_n    = sample_q + LIMIT_W'(1);
				end
				if (item.seq == next_expected_q) begin
					snap.verdict    = VERDICT_IN_ORDER;
					next_expected_n = item.seq + SEQ_W'(1);
				end else if (item.seq > next_expected_q) begin
					snap.verdict    = VERDICT_GAP;
					snap.lost_count = sat_add_u32(lost_q, item.seq - next_expected_q);
					next_expected_n = item.seq + SEQ_W'(1);
				end else begin
					snap.verdict       = VERDICT_OUT_OF_ORDER;
					snap.reorder_count = sat_inc32(reorder_q);
				end
			end
			prev_arrival_n = item.arrival;
			// one-way delay sum and extremes
			snap.delay_sum = sat_add_s64(delay_sum_q, item.owd);
			if (!started_q || item.owd < delay_low_q)
				snap.delay_min = item.owd;
			if (!started_q || item.owd > delay_high_q)
				snap.delay_max = item.owd;
			started_n          = 1'b1;
			snap.byte_total    = sat_add_u64(bytes_q, WORD_W'(item.len));
			snap.payload_total = sat_add_u64(payload_q, WORD_W'(item.pay));
			snap.valid_count   = sat_inc32(valid_q);
		end
	end

	// running state, updated as the word leaves this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			next_expected_q <= '0;
			prev_arrival_q  <= '0;
			valid_q         <= '0;
			corrupt_q       <= '0;
			lost_q          <= '0;
			reorder_q       <= '0;
			bytes_q         <= '0;
			payload_q       <= '0;
			delay_sum_q     <= '0;
			delay_low_q     <= '0;
			delay_high_q    <= '0;
			sample_q        <= '0;
		end else if (commit) begin
			started_q       <= started_n;
			next_expected_q <= next_expected_n;
			prev_arrival_q  <= prev_arrival_n;
			valid_q         <= snap.valid_count;
			corrupt_q       <= snap.corrupt_count;
			lost_q          <= snap.lost_count;
			reorder_q       <= snap.reorder_count;
			bytes_q         <= snap.byte_total;
			payload_q       <= snap.payload_total;
			delay_sum_q     <= snap.delay_sum;
			delay_low_q     <= snap.delay_min;
			delay_high_q    <= snap.delay_max;
			sample_q        <= sample_n;
		end
	end

endmodule
`default_nettype wire

@@ rtl/udp_test_stream_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Checks a stream of test datagram summaries, one word per clock cycle sustained while
// result_stall is low. Sixteen byte lanes compare the first and last eight payload bytes
// with the fill pattern in parallel; the statistics stage updates every tally, the delay
// sum and extremes and the arrival reference. The jitter sum and the sum of squares (one
// 32 by 32 multiply) follow in two more stages. A result that waits on result_stall does
// not hold up the stages behind it until they fill. Configuration is taken at any write;
// write it only while no word is in flight.
module udp_test_stream_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire udpchk_pkg::in_t                     item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output udpchk_pkg::out_t                         result,
	input  wire logic                                cfg_we,
	input  wire logic [udpchk_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [udpchk_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import udpchk_pkg::*;

	// configuration registers
	logic [SKEW_W-1:0]  skew_q;
	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skew_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CLOCK_SKEW:   skew_q <= cfg_data[SKEW_W-1:0];
				REG_SAMPLE_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage occupancy and flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || !result_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign item_stall   = !rdy1;
	assign result_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: capture, fold sequence, raw delay, length checks
	in_t               item_s1;
	logic [FOLD_W-1:0] fold_s1;
	logic              short_s1;
	logic [LEN_W-1:0]  pay_s1;
	logic [WORD_W-1:0] rawd_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && item_valid) begin
			item_s1  <= item;
			fold_s1  <= seq_fold(item.seq_number);
			short_s1 <= item.datagram_bytes < LEN_W'(HEADER_BYTES);
			pay_s1   <= item.datagram_bytes - LEN_W'(HEADER_BYTES);
			rawd_s1  <= item.arrival_ns - item.sent_ns;
		end
	end

	// stage 2: fill byte and skew-corrected delay
	logic [WORD_W:0]   skew_ext;
	logic [WORD_W:0]   owd_wide;
	logic [WORD_W-1:0] owd_sat;

	always_comb begin
		skew_ext = {{(WORD_W + 1 - SKEW_W){skew_q[SKEW_W-1]}}, skew_q};
		owd_wide = {rawd_s1[WORD_W-1], rawd_s1} - skew_ext;
		if (owd_wide[WORD_W] != owd_wide[WORD_W-1])
			owd_sat = owd_wide[WORD_W] ? S64_MIN : S64_MAX;
		else
			owd_sat = owd_wide[WORD_W-1:0];
	end

	logic [7:0]        chr_s2;
	logic [WORD_W-1:0] owd_s2;
	logic [WORD_W-1:0] head_s2, tail_s2, arrival_s2;
	logic [SEQ_W-1:0]  seq_s2;
	logic [LEN_W-1:0]  len_s2, pay_s2;
	logic              short_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			chr_s2     <= pattern_char(fold_s1);
			owd_s2     <= owd_sat;
			head_s2    <= item_s1.head_word;
			tail_s2    <= item_s1.tail_word;
			arrival_s2 <= item_s1.arrival_ns;
			seq_s2     <= item_s1.seq_number;
			len_s2     <= item_s1.datagram_bytes;
			pay_s2     <= pay_s1;
			short_s2   <= short_s1;
		end
	end

	// stage 3: byte lanes over head and tail, merged into one mismatch flag
	logic [BYTE_LANES-1:0] head_miss, tail_miss;
	logic                  tail_en;

	assign tail_en = pay_s2 >= LEN_W'(BYTE_LANES);

	for (genvar i = 0; i < BYTE_LANES; i++) begin : g_lane
		udpchk_lane u_head (
			.data_byte    (head_s2[8*i +: 8]),
			.pattern_byte (chr_s2),
			.enable       (pay_s2 > LEN_W'(i)),
			.mismatch     (head_miss[i])
		);
		udpchk_lane u_tail (
			.data_byte    (tail_s2[8*i +: 8]),
			.pattern_byte (chr_s2),
			.enable       (tail_en),
			.mismatch     (tail_miss[i])
		);
	end

	stats_item_t item_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			item_s3.short_pkt <= short_s2;
			item_s3.bad       <= (|head_miss) || (|tail_miss);
			item_s3.seq       <= seq_s2;
			item_s3.len       <= len_s2;
			item_s3.pay       <= pay_s2;
			item_s3.owd       <= owd_s2;
			item_s3.arrival   <= arrival_s2;
		end
	end

	// stage 4: statistics update
	stats_snap_t snap;
	stats_snap_t snap_s4;

	udpchk_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (rdy4 && v_s3),
		.item         (item_s3),
		.sample_limit (limit_q),
		.snap         (snap)
	);

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3)
			snap_s4 <= snap;
	end

	// stage 5: inter-arrival sum and square of the clipped gap
	logic [WORD_W-1:0] gap_acc_q, gap_next;
	logic [CNT_W-1:0]  gap_clip;
	logic [WORD_W-1:0] gap_square;

	always_comb begin
		gap_next   = snap_s4.sample ? sat_add_u64(gap_acc_q, snap_s4.gap) : gap_acc_q;
		gap_clip   = (|snap_s4.gap[WORD_W-1:CNT_W]) ? '1 : snap_s4.gap[CNT_W-1:0];
		gap_square = gap_clip * gap_clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_acc_q <= '0;
		else if (rdy5 && v_s4)
			gap_acc_q <= gap_next;
	end

	out_t              res_s5;
	logic [WORD_W-1:0] square_s5;
	logic              sample_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			res_s5.verdict        <= snap_s4.verdict;
			res_s5.valid_count    <= snap_s4.valid_count;
			res_s5.corrupt_count  <= snap_s4.corrupt_count;
			res_s5.lost_count     <= snap_s4.lost_count;
			res_s5.reorder_count  <= snap_s4.reorder_count;
			res_s5.byte_total     <= snap_s4.byte_total;
			res_s5.payload_total  <= snap_s4.payload_total;
			res_s5.delay_sum      <= snap_s4.delay_sum;
			res_s5.delay_min      <= snap_s4.delay_min;
			res_s5.delay_max      <= snap_s4.delay_max;
			res_s5.gap_sum        <= gap_next;
			res_s5.gap_square_sum <= '0;
			square_s5             <= gap_square;
			sample_s5             <= snap_s4.sample;
		end
	end

	// stage 6: sum of squares and result register
	logic [WORD_W-1:0] sq_acc_q, sq_next;
	out_t              result_s6, result_n;

	assign sq_next = sample_s5 ? sat_add_u64(sq_acc_q, square_s5) : sq_acc_q;

	// stage 5 word with the new sum of squares merged in
	always_comb begin
		result_n                = res_s5;
		result_n.gap_square_sum = sq_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_acc_q <= '0;
		else if (rdy6 && v_s5)
			sq_acc_q <= sq_next;
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5)
			result_s6 <= result_n;
	end

	assign result = result_s6;

	// a gap always adds at least one lost sequence number
	a_gap_counts_loss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && snap_s4.verdict == VERDICT_GAP |-> snap_s4.lost_count != '0)
		else $error("gap verdict with zero lost count");

	// the first valid datagram is the only one counted so far
	a_first_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && snap_s4.verdict == VERDICT_FIRST |-> snap_s4.valid_count == CNT_W'(1))
		else $error("first valid verdict with valid count other than one");

	// an accepted word lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> v_s1)
		else $error("accepted word lost at stage 1");

	// an empty first stage never stalls the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !item_stall)
		else $error("input stalled with stage 1 empty");

endmodule
`default_nettype wire
